// ===== hw/rtl/baro_pkg.sv =====
package baro_pkg;

   localparam int DivBits = 32;

   localparam logic [31:0] TfOffset  = 32'd64000;
   localparam logic [31:0] PressBase = 32'd1048576;
   localparam logic [31:0] PressMul  = 32'd3125;
   localparam logic [31:0] DivHalf   = 32'd32768;
   localparam logic [31:0] Round8    = 32'd128;

   typedef enum logic [1:0] {
      REG_TEMP_CALIB   = 2'd0,
      REG_PRESS_FIRST  = 2'd1,
      REG_PRESS_MIDDLE = 2'd2,
      REG_PRESS_LAST   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] temp;
      logic        invalid;
      logic        scale;
   } div_tag_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

endpackage

// ===== hw/rtl/baro_div.sv =====
module baro_div
   import baro_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_dividend,
   input  logic [31:0] in_divisor,
   input  div_tag_type in_tag,
   output logic        out_valid,
   output logic [31:0] out_quot,
   output div_tag_type out_tag
);

   logic [31:0] r_ff   [0:DivBits-1];
   logic [31:0] n_ff   [0:DivBits-1];
   logic [31:0] q_ff   [0:DivBits-1];
   logic [31:0] d_ff   [0:DivBits-1];
   div_tag_type tag_ff [0:DivBits-1];
   logic        vld_ff [0:DivBits-1];

   genvar k;
   generate
      for (k = 0; k < DivBits; k++) begin : g_stage
         logic [31:0] r_src, n_src, q_src, d_src;
         div_tag_type tag_src;
         logic        vld_src;
         logic [32:0] rr;
         logic [32:0] diff;
         if (k == 0) begin : g_first
            assign r_src   = '0;
            assign n_src   = in_dividend;
            assign q_src   = '0;
            assign d_src   = in_divisor;
            assign tag_src = in_tag;
            assign vld_src = in_valid;
         end else begin : g_rest
            assign r_src   = r_ff[k-1];
            assign n_src   = n_ff[k-1];
            assign q_src   = q_ff[k-1];
            assign d_src   = d_ff[k-1];
            assign tag_src = tag_ff[k-1];
            assign vld_src = vld_ff[k-1];
         end
         assign rr   = {r_src, n_src[31]};
         assign diff = rr - {1'b0, d_src};
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_src;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               if (!diff[32]) begin
                  r_ff[k] <= diff[31:0];
                  q_ff[k] <= {q_src[30:0], 1'b1};
               end else begin
                  r_ff[k] <= rr[31:0];
                  q_ff[k] <= {q_src[30:0], 1'b0};
               end
               n_ff[k]   <= {n_src[30:0], 1'b0};
               d_ff[k]   <= d_src;
               tag_ff[k] <= tag_src;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[DivBits-1];
   assign out_quot  = q_ff[DivBits-1];
   assign out_tag   = tag_ff[DivBits-1];

endmodule

// ===== hw/rtl/baro_sensor_compensation_top.sv =====
// From an accepted request to its result there are nine arithmetic
// stages, a 32-stage restoring divider that retires one quotient bit per stage, and
// three correction stages. Throughput: one request per cycle; the whole pipeline
// stalls only while a result waits on the output. Reset clears all valid bits and
// the four calibration registers to zero.
module baro_sensor_compensation_top
   import baro_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // raw_temp[19:0], raw_press[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // temperature_centi[31:0], pressure_pa[63:32]
   output logic        rsp_tuser,  // pressure_invalid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] tcal_ff, pc1_ff, pc2_ff, pc3_ff;
   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic        en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff <= '0;
         pc1_ff  <= '0;
         pc2_ff  <= '0;
         pc3_ff  <= '0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_TEMP_CALIB:   tcal_ff <= csr_data;
            REG_PRESS_FIRST:  pc1_ff  <= csr_data;
            REG_PRESS_MIDDLE: pc2_ff  <= csr_data;
            REG_PRESS_LAST:   pc3_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign t1 = {16'd0, tcal_ff[15:0]};
   assign t2 = sx16(tcal_ff[31:16]);
   assign t3 = sx16(tcal_ff[47:32]);
   assign p1 = {16'd0, pc1_ff[15:0]};
   assign p2 = sx16(pc1_ff[31:16]);
   assign p3 = sx16(pc1_ff[47:32]);
   assign p4 = sx16(pc2_ff[15:0]);
   assign p5 = sx16(pc2_ff[31:16]);
   assign p6 = sx16(pc2_ff[47:32]);
   assign p7 = sx16(pc3_ff[15:0]);
   assign p8 = sx16(pc3_ff[31:16]);
   assign p9 = sx16(pc3_ff[47:32]);

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [8:0]  vld_ff;
   logic [31:0] raw_t, raw_p, x1, d;
   logic [31:0] s1_pa_ff, s1_dd_ff;
   logic [31:0] s2_a_ff, s2_mb_ff;
   logic [31:0] s3_tf_ff;
   logic [31:0] s4_temp_ff, s4_v1_ff, s4_q_ff;
   logic [31:0] s5_qq_ff, s5_m5_ff, s5_m2_ff, s5_temp_ff;
   logic [31:0] s6_v2a_ff, s6_v2b_ff, s6_m3_ff, s6_m2s_ff, s6_temp_ff;
   logic [31:0] s7_v2_ff, s7_v1_ff, s7_temp_ff;
   logic [31:0] s8_m1_ff, s8_v2_ff, s8_temp_ff;
   logic [31:0] s9_div_ff, s9_c_ff, s9_temp_ff;
   logic [31:0] p_ff [1:8];

   assign raw_t = {12'd0, req_tdata[19:0]};
   assign raw_p = {12'd0, req_tdata[39:20]};
   assign x1    = (raw_t >> 3) - (t1 << 1);
   assign d     = (raw_t >> 4) - t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pa_ff   <= x1 * t2;
         s1_dd_ff   <= d * d;
         p_ff[1]    <= raw_p;
         s2_a_ff    <= asr32(s1_pa_ff, 5'd11);
         s2_mb_ff   <= asr32(s1_dd_ff, 5'd12) * t3;
         p_ff[2]    <= p_ff[1];
         s3_tf_ff   <= s2_a_ff + asr32(s2_mb_ff, 5'd14);
         p_ff[3]    <= p_ff[2];
         s4_temp_ff <= asr32(s3_tf_ff * 32'd5 + Round8, 5'd8);
         s4_v1_ff   <= asr32(s3_tf_ff, 5'd1) - TfOffset;
         s4_q_ff    <= asr32(asr32(s3_tf_ff, 5'd1) - TfOffset, 5'd2);
         p_ff[4]    <= p_ff[3];
         s5_qq_ff   <= s4_q_ff * s4_q_ff;
         s5_m5_ff   <= s4_v1_ff * p5;
         s5_m2_ff   <= p2 * s4_v1_ff;
         s5_temp_ff <= s4_temp_ff;
         p_ff[5]    <= p_ff[4];
         s6_v2a_ff  <= asr32(s5_qq_ff, 5'd11) * p6;
         s6_v2b_ff  <= s5_m5_ff << 1;
         s6_m3_ff   <= p3 * asr32(s5_qq_ff, 5'd13);
         s6_m2s_ff  <= asr32(s5_m2_ff, 5'd1);
         s6_temp_ff <= s5_temp_ff;
         p_ff[6]    <= p_ff[5];
         s7_v2_ff   <= asr32(s6_v2a_ff + s6_v2b_ff, 5'd2) + (p4 << 16);
         s7_v1_ff   <= asr32(asr32(s6_m3_ff, 5'd3) + s6_m2s_ff, 5'd18);
         s7_temp_ff <= s6_temp_ff;
         p_ff[7]    <= p_ff[6];
         s8_m1_ff   <= (DivHalf + s7_v1_ff) * p1;
         s8_v2_ff   <= s7_v2_ff;
         s8_temp_ff <= s7_temp_ff;
         p_ff[8]    <= p_ff[7];
         s9_div_ff  <= asr32(s8_m1_ff, 5'd15);
         s9_c_ff    <= ((PressBase - p_ff[8]) - asr32(s8_v2_ff, 5'd12)) * PressMul;
         s9_temp_ff <= s8_temp_ff;
      end
   end

   div_tag_type div_in_tag, div_out_tag;
   logic        div_out_vld;
   logic [31:0] div_quot, div_dividend;

   assign div_in_tag.temp    = s9_temp_ff;
   assign div_in_tag.invalid = (s9_div_ff == '0);
   assign div_in_tag.scale   = s9_c_ff[31];
   assign div_dividend       = s9_c_ff[31] ? s9_c_ff : (s9_c_ff << 1);

   baro_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vld_ff[8]),
      .in_dividend (div_dividend),
      .in_divisor  (s9_div_ff),
      .in_tag      (div_in_tag),
      .out_valid   (div_out_vld),
      .out_quot    (div_quot),
      .out_tag     (div_out_tag)
   );

   logic [31:0] c_q;
   logic [31:0] c1_c_ff, c1_cc_ff, c1_mb_ff, c2_c_ff, c2_a_ff, c2_b_ff;
   div_tag_type c1_tag_ff, c2_tag_ff;
   logic        c1_vld_ff, c2_vld_ff, out_vld_ff;
   logic [31:0] out_temp_ff, out_press_ff;
   logic        out_inv_ff;

   assign c_q = div_out_tag.scale ? (div_quot << 1) : div_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         c1_vld_ff  <= div_out_vld;
         c2_vld_ff  <= c1_vld_ff;
         out_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_c_ff      <= c_q;
         c1_cc_ff     <= (c_q >> 3) * (c_q >> 3);
         c1_mb_ff     <= (c_q >> 2) * p8;
         c1_tag_ff    <= div_out_tag;
         c2_c_ff      <= c1_c_ff;
         c2_a_ff      <= p9 * (c1_cc_ff >> 13);
         c2_b_ff      <= asr32(c1_mb_ff, 5'd13);
         c2_tag_ff    <= c1_tag_ff;
         out_temp_ff  <= c2_tag_ff.temp;
         out_inv_ff   <= c2_tag_ff.invalid;
         out_press_ff <= c2_tag_ff.invalid ? '0 :
                         c2_c_ff + asr32(asr32(c2_a_ff, 5'd12) + c2_b_ff + p7, 5'd4);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_press_ff, out_temp_ff};
   assign rsp_tuser  = out_inv_ff;

endmodule

// ===== hw/rtl/baro_chk.sv =====
module baro_chk
   import baro_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // An invalid pressure is always reported as zero pascals.
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:32] == 32'd0)
      else $error("invalid pressure with nonzero value");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // With no result pending, the block takes new requests.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind baro_sensor_compensation_top baro_chk u_baro_chk (.*);
